### hdl/clsw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package clsw_pkg;

  localparam int unsigned LineLenW  = 6;
  localparam int unsigned AddrW     = 7;
  localparam int unsigned CountW    = 7;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 7;

  localparam logic [7:0] ClearInstr   = 8'h01;
  localparam logic [7:0] SetAddrInstr = 8'h80;

  localparam logic [CfgIdxW-1:0] RegLineLength = 2'd0;
  localparam logic [CfgIdxW-1:0] RegSecondLine = 2'd1;

  // slot of the nibble currently on the output
  typedef enum logic [1:0] {
    SlotPreHi  = 2'd0,
    SlotPreLo  = 2'd1,
    SlotDataHi = 2'd2,
    SlotDataLo = 2'd3
  } slot_e;

  // up to two bytes per item: an optional inserted instruction, then the item's byte
  typedef struct packed {
    logic       has_prefix;
    logic [7:0] prefix_byte;
    logic       prefix_wait;
    logic       data_rs;
    logic [7:0] data_byte;
  } job_t;

endpackage

`default_nettype wire

### hdl/clsw_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface clsw_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] value;

  modport source (output valid, output command, output value, input ready);
  modport sink (input valid, input command, input value, output ready);
endinterface

`default_nettype wire

### hdl/clsw_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface clsw_out_if;
  logic       valid;
  logic       ready;
  logic       register_select;
  logic [3:0] nibble;
  logic       long_wait;
  logic       last;

  modport source (output valid, output register_select, output nibble,
                  output long_wait, output last, input ready);
  modport sink (input valid, input register_select, input nibble,
                input long_wait, input last, output ready);
endinterface

`default_nettype wire

### hdl/char_lcd_stream_writer.sv
// The first nibble of an item is on the output in the cycle after its input beat.
// One nibble beat per cycle unless stalled; an item is two beats (instruction, or a
// character with no line change) or four (character with an inserted instruction).
// The job register is reloaded in the cycle its final nibble is taken, so items run
// back to back. Reset (rst_ni, asynchronous) clears the position count, empties the
// output and sets line length 16 and second-line address 64.
`timescale 1ns / 1ps
`default_nettype none

module char_lcd_stream_writer (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [clsw_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [clsw_pkg::CfgDataW-1:0] cfg_data_i,
  clsw_in_if.sink                            in_i,
  clsw_out_if.source                         out_o
);

  clsw_pkg::job_t job;
  logic           free;
  logic           accept;

  assign in_i.ready = free;
  assign accept     = in_i.valid && free;

  clsw_decode u_decode (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .accept_i   (accept),
    .command_i  (in_i.command),
    .value_i    (in_i.value),
    .job_o      (job)
  );

  clsw_serial u_serial (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .job_i       (job),
    .free_o      (free),
    .valid_o     (out_o.valid),
    .ready_i     (out_o.ready),
    .rs_o        (out_o.register_select),
    .nibble_o    (out_o.nibble),
    .long_wait_o (out_o.long_wait),
    .last_o      (out_o.last)
  );

endmodule

`default_nettype wire

### hdl/clsw_decode.sv
`timescale 1ns / 1ps
`default_nettype none

module clsw_decode (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [clsw_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [clsw_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire logic                          accept_i,
  input  wire logic                          command_i,
  input  wire logic [7:0]                    value_i,
  output clsw_pkg::job_t                     job_o
);

  logic [clsw_pkg::LineLenW-1:0] line_len_q;
  logic [clsw_pkg::AddrW-1:0]    line2_addr_q;
  logic [clsw_pkg::CountW-1:0]   count_q, count_d;
  logic                          at_clear, at_line2;

  // twice the line length is at most 126, so it fits the count width
  assign at_clear = (count_q == {line_len_q, 1'b0});
  assign at_line2 = (count_q == {1'b0, line_len_q});

  always_comb begin
    job_o.has_prefix  = 1'b0;
    job_o.prefix_byte = clsw_pkg::ClearInstr;
    job_o.prefix_wait = 1'b0;
    job_o.data_rs     = ~command_i;
    job_o.data_byte   = value_i;
    count_d           = count_q;
    if (!command_i) begin
      count_d = count_q + 1'b1;
      if (at_clear) begin
        job_o.has_prefix  = 1'b1;
        job_o.prefix_wait = 1'b1;
        count_d           = {{(clsw_pkg::CountW-1){1'b0}}, 1'b1};
      end else if (at_line2) begin
        job_o.has_prefix  = 1'b1;
        job_o.prefix_byte = clsw_pkg::SetAddrInstr | {1'b0, line2_addr_q};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_len_q   <= clsw_pkg::LineLenW'(16);
      line2_addr_q <= clsw_pkg::AddrW'(64);
      count_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          clsw_pkg::RegLineLength: line_len_q   <= cfg_data_i[clsw_pkg::LineLenW-1:0];
          clsw_pkg::RegSecondLine: line2_addr_q <= cfg_data_i[clsw_pkg::AddrW-1:0];
          default: ;
        endcase
      end
      if (accept_i) begin
        count_q <= count_d;
      end
    end
  end

endmodule

`default_nettype wire

### hdl/clsw_serial.sv
`timescale 1ns / 1ps
`default_nettype none

module clsw_serial (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        load_i,
  input  wire clsw_pkg::job_t job_i,
  output logic             free_o,
  output logic             valid_o,
  input  wire logic        ready_i,
  output logic             rs_o,
  output logic [3:0]       nibble_o,
  output logic             long_wait_o,
  output logic             last_o
);

  clsw_pkg::job_t  job_q;
  clsw_pkg::slot_e slot_q;
  logic            busy_q;
  logic            beat;

  assign beat     = busy_q && ready_i;
  assign last_o   = (slot_q == clsw_pkg::SlotDataLo);
  // the job register frees up in the cycle its final beat goes out
  assign free_o   = !busy_q || (ready_i && last_o);
  assign valid_o  = busy_q;

  always_comb begin
    rs_o        = 1'b0;
    long_wait_o = 1'b0;
    case (slot_q)
      clsw_pkg::SlotPreHi:  nibble_o = job_q.prefix_byte[7:4];
      clsw_pkg::SlotPreLo: begin
        nibble_o    = job_q.prefix_byte[3:0];
        long_wait_o = job_q.prefix_wait;
      end
      clsw_pkg::SlotDataHi: begin
        nibble_o = job_q.data_byte[7:4];
        rs_o     = job_q.data_rs;
      end
      clsw_pkg::SlotDataLo: begin
        nibble_o = job_q.data_byte[3:0];
        rs_o     = job_q.data_rs;
      end
      default: nibble_o = job_q.data_byte[3:0];
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      slot_q <= clsw_pkg::SlotDataHi;
    end else if (load_i) begin
      busy_q <= 1'b1;
      slot_q <= job_i.has_prefix ? clsw_pkg::SlotPreHi : clsw_pkg::SlotDataHi;
    end else if (beat) begin
      if (last_o) begin
        busy_q <= 1'b0;
      end else begin
        slot_q <= clsw_pkg::slot_e'(slot_q + 2'd1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      job_q <= job_i;
    end
  end

endmodule

`default_nettype wire

### hdl/clsw_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module clsw_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_i,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic       out_rs_i,
  input wire logic [3:0] out_nibble_i,
  input wire logic       out_long_wait_i,
  input wire logic       out_last_i
);

  // stalled beat holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_nibble_i)
      && $stable(out_last_i) && $stable(out_rs_i) && $stable(out_long_wait_i))
    else $error("stalled output beat changed");

  // long wait only on the low nibble of an inserted clear
  a_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_long_wait_i |-> !out_rs_i && (out_nibble_i == 4'h1) && !out_last_i)
    else $error("long_wait on a beat that is not a clear low nibble");

  // an item's beats come without gaps
  a_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !out_last_i |=> out_valid_i)
    else $error("gap inside an item's transfers");

  // accepted item shows on the output next cycle
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> out_valid_i)
    else $error("accepted item produced no output beat");

endmodule

bind char_lcd_stream_writer clsw_checker u_clsw_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .out_rs_i        (out_o.register_select),
  .out_nibble_i    (out_o.nibble),
  .out_long_wait_i (out_o.long_wait),
  .out_last_i      (out_o.last)
);

`default_nettype wire

### bench/tb_char_lcd_stream_writer.sv
`timescale 1ns / 1ps

module tb_char_lcd_stream_writer;

  localparam logic CmdChar  = 1'b0;
  localparam logic CmdInstr = 1'b1;
  localparam logic RsInstr  = 1'b0;
  localparam logic RsData   = 1'b1;

  // indexes past the register list, writes to them must be ignored
  localparam logic [clsw_pkg::CfgIdxW-1:0] RegSpareA = 2'd2;
  localparam logic [clsw_pkg::CfgIdxW-1:0] RegSpareB = 2'd3;

  localparam int WatchdogLimit = 2000;

  typedef struct packed {
    logic       rs;
    logic [3:0] nibble;
    logic       long_wait;
    logic       last;
  } lcd_xfer_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [clsw_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [clsw_pkg::CfgDataW-1:0] cfg_data_i;

  clsw_in_if  in_if ();
  clsw_out_if out_if ();

  char_lcd_stream_writer u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if.sink),
    .out_o      (out_if.source)
  );

  always #6 clk_i = ~clk_i;

  // shadow of the block's registers and position count
  logic [clsw_pkg::LineLenW-1:0] line_len    = 6'd16;
  logic [clsw_pkg::AddrW-1:0]    second_addr = 7'd64;
  logic [clsw_pkg::CountW-1:0]   char_pos    = '0;

  lcd_xfer_t pending_xfers[$];

  int mismatches  = 0;
  int gap_pct     = 0;
  int stall_pct   = 0;
  int hold_left   = 0;
  int idle_cycles = 0;

  function automatic void push_byte(input logic rs, input logic [7:0] byte_val,
                                    input logic wait_low, input logic is_last);
    lcd_xfer_t x;
    x = '{rs: rs, nibble: byte_val[7:4], long_wait: 1'b0, last: 1'b0};
    pending_xfers.push_back(x);
    x = '{rs: rs, nibble: byte_val[3:0], long_wait: wait_low, last: is_last};
    pending_xfers.push_back(x);
  endfunction

  function automatic void predict_transfers(input logic cmd, input logic [7:0] val);
    if (cmd == CmdInstr) begin
      push_byte(RsInstr, val, 1'b0, 1'b1);
    end else begin
      // clear check wins over the second-line check
      if (char_pos == {line_len, 1'b0}) begin
        push_byte(RsInstr, clsw_pkg::ClearInstr, 1'b1, 1'b0);
        char_pos = '0;
      end else if (char_pos == {1'b0, line_len}) begin
        push_byte(RsInstr, clsw_pkg::SetAddrInstr | {1'b0, second_addr}, 1'b0, 1'b0);
      end
      push_byte(RsData, val, 1'b0, 1'b1);
      char_pos = char_pos + 1'b1;
    end
  endfunction

  task automatic write_reg(input logic [clsw_pkg::CfgIdxW-1:0] idx,
                           input logic [clsw_pkg::CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    if (idx == clsw_pkg::RegLineLength) begin
      line_len = data[clsw_pkg::LineLenW-1:0];
    end else if (idx == clsw_pkg::RegSecondLine) begin
      second_addr = data;
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_item(input logic cmd, input logic [7:0] val);
    in_if.valid   <= 1'b1;
    in_if.command <= cmd;
    in_if.value   <= val;
    do @(posedge clk_i); while (!in_if.ready);
    predict_transfers(cmd, val);
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < gap_pct);
    end
  endtask

  task automatic send_random(input int n, input int instr_pct);
    logic cmd;
    repeat (n) begin
      cmd = ($urandom_range(99) < instr_pct) ? CmdInstr : CmdChar;
      send_item(cmd, 8'($urandom_range(255)));
    end
  endtask

  // block is idle once every transfer is out; a few spare cycles on top
  task automatic drain();
    in_if.valid <= 1'b0;
    while (pending_xfers.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic test_directed_cases();
    gap_pct   = 0;
    stall_pct = 0;
    // zero line length from count zero: clear only, no set-address
    write_reg(clsw_pkg::RegLineLength, 7'd0);
    write_reg(clsw_pkg::RegSecondLine, 7'd127);
    send_item(CmdInstr, 8'h00);
    send_item(CmdInstr, 8'hFF);
    send_item(CmdInstr, clsw_pkg::ClearInstr);  // raw clear: no long wait, count untouched
    send_item(CmdInstr, 8'h80);
    send_item(CmdChar, 8'h00);
    send_item(CmdChar, 8'hFF);
    drain();
    write_reg(clsw_pkg::RegLineLength, 7'h41);  // bit 6 dropped, gives 1
    send_item(CmdChar, 8'h55);
    send_item(CmdChar, 8'hAA);
    send_item(CmdInstr, clsw_pkg::ClearInstr);
    send_item(CmdChar, 8'h5A);
    drain();
    write_reg(RegSpareA, 7'h7F);
    write_reg(RegSpareB, 7'h00);
    write_reg(clsw_pkg::RegSecondLine, 7'd0);
    send_item(CmdChar, 8'hA5);
    send_item(CmdInstr, 8'h7F);
    drain();
    write_reg(clsw_pkg::RegLineLength, 7'h3F);
    send_item(CmdChar, 8'h0F);
    send_item(CmdChar, 8'hF0);
    send_item(CmdInstr, 8'hC0);
    send_item(CmdChar, 8'h81);
    drain();
  endtask

  // line length dropped under the count: count runs on to the wrap
  task automatic test_count_wrap();
    gap_pct   = 53;
    stall_pct = 0;
    write_reg(clsw_pkg::RegLineLength, 7'd40);
    write_reg(clsw_pkg::RegSecondLine, 7'd64);
    send_random(60, 0);
    drain();
    write_reg(clsw_pkg::RegLineLength, 7'd2);
    send_random(80, 0);
    drain();
  endtask

  task automatic test_default_geometry();
    gap_pct   = 0;
    stall_pct = 0;
    write_reg(clsw_pkg::RegLineLength, 7'd16);
    write_reg(clsw_pkg::RegSecondLine, 7'd64);
    send_random(60, 15);
    drain();
  endtask

  task automatic test_receiver_stalls();
    gap_pct   = 0;
    stall_pct = 53;
    write_reg(clsw_pkg::RegLineLength, 7'd40);
    write_reg(clsw_pkg::RegSecondLine, 7'd127);
    send_random(60, 15);
    drain();
  endtask

  task automatic test_both_idle();
    gap_pct   = 21;
    stall_pct = 21;
    write_reg(clsw_pkg::RegLineLength, 7'd1);
    write_reg(clsw_pkg::RegSecondLine, 7'h27);
    send_random(30, 20);
    drain();
    write_reg(clsw_pkg::RegLineLength, 7'd7);
    send_random(30, 20);
    drain();
  endtask

  task automatic test_backpressure();
    gap_pct   = 0;
    stall_pct = 0;
    write_reg(clsw_pkg::RegLineLength, 7'd3);
    write_reg(clsw_pkg::RegSecondLine, 7'h55);
    hold_left = 150;
    send_random(30, 15);
    drain();
  endtask

  initial begin
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= clsw_pkg::RegLineLength;
    cfg_data_i    <= '0;
    in_if.valid   <= 1'b0;
    in_if.command <= CmdChar;
    in_if.value   <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();
    test_count_wrap();
    test_default_geometry();
    test_receiver_stalls();
    test_both_idle();
    test_backpressure();

    drain();
    repeat (8) @(posedge clk_i);
    if (pending_xfers.size() != 0) begin
      $display("%0t: %0d transfers never arrived", $time, pending_xfers.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // receiver: random stalls, plus a long hold-off when asked
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    lcd_xfer_t got, want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = '{rs: out_if.register_select, nibble: out_if.nibble,
              long_wait: out_if.long_wait, last: out_if.last};
      if (pending_xfers.size() == 0) begin
        $display("%0t: unexpected beat rs=%0d nibble=%h long_wait=%0d last=%0d",
                 $time, got.rs, got.nibble, got.long_wait, got.last);
        mismatches++;
      end else begin
        want = pending_xfers.pop_front();
        if (got.rs !== want.rs || got.nibble !== want.nibble ||
            got.long_wait !== want.long_wait || got.last !== want.last) begin
          $display({"%0t: expected rs=%0d nibble=%h long_wait=%0d last=%0d, ",
                    "got rs=%0d nibble=%h long_wait=%0d last=%0d"},
                   $time, want.rs, want.nibble, want.long_wait, want.last,
                   got.rs, got.nibble, got.long_wait, got.last);
          mismatches++;
        end
      end
    end
  end

  // no beat on either side for too long: give up
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("%0t: watchdog expired", $time);
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

### char_lcd_stream_writer.f
hdl/clsw_pkg.sv
hdl/clsw_in_if.sv
hdl/clsw_out_if.sv
hdl/clsw_decode.sv
hdl/clsw_serial.sv
hdl/char_lcd_stream_writer.sv
hdl/clsw_checker.sv
bench/tb_char_lcd_stream_writer.sv
